// File: hdl/assert_macros.svh
// Assertion macros included by priority_lock_wait_queue.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds while rst_n is high.
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

// File: hdl/plwq_pkg.sv
package plwq_pkg;

  localparam logic ACT_ENTER = 1'b0;
  localparam logic ACT_EXIT  = 1'b1;

  localparam logic [2:0] ST_GRANTED = 3'd0;
  localparam logic [2:0] ST_QUEUED  = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_HANDED  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic       action;
    logic [7:0] requester;
    logic [7:0] priority_req;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] new_owner;
    logic [4:0] waiting;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_POP
  } state_t;

endpackage

// File: hdl/plwq_ram.sv
module plwq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/priority_lock_wait_queue.sv
// Results: grant, free and queue-full results appear in the cycle after start is taken;
// a hand-over goes through the S_POP state first, and a queued insert walks from the
// queue tail in S_INSERT, moving one entry per cycle through the single read and write
// port of the queue RAM.
// Flow: start is taken only while busy is low, so a new item waits until the last one is done;
// results are single-cycle strobes on out_valid that the receiver cannot stall.
// Reset (rst_n low, synchronous) frees the lock and empties the queue; the RAM is not cleared.
`include "assert_macros.svh"

module priority_lock_wait_queue #(
  parameter int QUEUE_DEPTH    = 16,
  parameter int PRIORITY_BITS  = 8,
  parameter int REQUESTER_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  plwq_pkg::in_t in_data,
  output logic          out_valid,
  output plwq_pkg::out_t out_data
);
  import plwq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = PRIORITY_BITS + REQUESTER_BITS;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0]  prio;
    logic [REQUESTER_BITS-1:0] who;
  } entry_t;

  state_t state_r, state_nxt;
  logic   lock_r, lock_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  entry_t key_r, key_nxt;
  out_t   out_r, out_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic          accept;
  logic          full;
  logic          stop;
  entry_t        in_entry;
  entry_t        rd_entry;
  logic [EW-1:0] rd_raw;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  logic [31:0]   cnt_wide;
  logic [31:0]   owner_wide;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
  endfunction

  assign accept         = start && !busy;
  assign busy           = (state_r != S_IDLE);
  assign full           = (cnt_r == CW'(QUEUE_DEPTH));
  assign in_entry.prio  = PRIORITY_BITS'(32'(in_data.priority_req));
  assign in_entry.who   = REQUESTER_BITS'(32'(in_data.requester));
  assign rd_entry       = entry_t'(rd_raw);
  assign stop           = (left_r == '0) || (rd_entry.prio >= key_r.prio);
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

  plwq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(EW'(ram_wdata)),
    .raddr(ram_raddr),
    .rdata(rd_raw)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == ACT_ENTER && lock_r && !full) begin
            state_nxt = S_INSERT;
          end else if (in_data.action == ACT_EXIT && cnt_r != '0) begin
            state_nxt = S_POP;
          end
        end
      end
      S_INSERT: begin
        if (stop) begin
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    lock_nxt      = lock_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    key_nxt       = key_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = rd_entry;
    ram_raddr     = head_r;
    cnt_wide      = 32'(cnt_r);
    owner_wide    = '0;
    case (state_r)
      S_IDLE: begin
        ram_raddr = (in_data.action == ACT_EXIT) ? head_r : ptr_dec(tail_r);
        if (accept) begin
          out_nxt.new_owner = '0;
          out_nxt.waiting   = cnt_wide[4:0];
          if (in_data.action == ACT_ENTER) begin
            if (!lock_r) begin
              lock_nxt       = 1'b1;
              out_nxt.status = ST_GRANTED;
              out_valid_nxt  = 1'b1;
            end else if (full) begin
              out_nxt.status = ST_FULL;
              out_valid_nxt  = 1'b1;
            end else begin
              key_nxt  = in_entry;
              wp_nxt   = tail_r;
              rp_nxt   = ptr_dec(tail_r);
              left_nxt = cnt_r;
            end
          end else if (cnt_r == '0) begin
            lock_nxt       = 1'b0;
            out_nxt.status = ST_FREED;
            out_valid_nxt  = 1'b1;
          end
        end
      end
      S_INSERT: begin
        ram_raddr = ptr_dec(rp_r);
        ram_we    = 1'b1;
        if (stop) begin
          ram_wdata         = key_r;
          cnt_nxt           = cnt_r + CW'(1);
          tail_nxt          = ptr_inc(tail_r);
          cnt_wide          = 32'(cnt_nxt);
          out_nxt.status    = ST_QUEUED;
          out_nxt.new_owner = '0;
          out_nxt.waiting   = cnt_wide[4:0];
          out_valid_nxt     = 1'b1;
        end else begin
          wp_nxt   = rp_r;
          rp_nxt   = ptr_dec(rp_r);
          left_nxt = left_r - CW'(1);
        end
      end
      S_POP: begin
        head_nxt          = ptr_inc(head_r);
        cnt_nxt           = cnt_r - CW'(1);
        cnt_wide          = 32'(cnt_nxt);
        owner_wide        = 32'(rd_entry.who);
        out_nxt.status    = ST_HANDED;
        out_nxt.new_owner = owner_wide[7:0];
        out_nxt.waiting   = cnt_wide[4:0];
        out_valid_nxt     = 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lock_r      <= 1'b0;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lock_r      <= lock_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wp_r  <= wp_nxt;
    rp_r  <= rp_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  `ASSERT_CLK(a_accept_answers, accept |=> (out_valid_r || busy))
  `ASSERT_NEVER(a_count_bound, cnt_r > CW'(QUEUE_DEPTH))
  `ASSERT_NEVER(a_walk_needs_owner, (state_r != S_IDLE) && !lock_r)
  `ASSERT_NEVER(a_waiters_need_owner, (cnt_r != '0) && !lock_r)

endmodule
